// ===== rtl/rms_vector_normalizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// RMS vector normaliser: assertion macros
// Shared property wrappers for the checker; clocked on clock, reset active high.
// ----------------------------------------------------------------------------
`ifndef RMS_VECTOR_NORMALIZER_UNIT_DEFINES_SVH
`define RMS_VECTOR_NORMALIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RVN_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RVN_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define RVN_ASSERT_NXT_NR(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rvn_pkg.sv =====
// ----------------------------------------------------------------------------
// RMS vector normaliser package
// Sizes, codes and sequencer states shared by the unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rvn_pkg;

   localparam int MAX_LENGTH = 4096;
   localparam int ADDR_W     = $clog2(MAX_LENGTH);
   localparam int LEN_W      = ADDR_W + 1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_READY = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam logic [1:0] CSR_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_EPSILON = 2'd1;
   localparam logic [1:0] CSR_WEIGHTS = 2'd2;

   localparam logic [LEN_W-1:0] LENGTH_RESET  = LEN_W'(MAX_LENGTH);
   localparam logic [15:0]      EPSILON_RESET = 16'd4295;
   localparam logic             WEIGHTS_RESET = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DROP,
      S_LD_SQ,
      S_LD_ACC,
      S_RT_DIV1,
      S_RT_MEAN,
      S_RT_DIV2,
      S_RT_SQRT,
      S_EM_READ,
      S_EM_SCALE,
      S_EM_MAG,
      S_EM_WLO,
      S_EM_WHI,
      S_EM_WSUM,
      S_EM_CLIP,
      S_PUSH
   } rvn_state_type;

endpackage

`default_nettype wire

// ===== rtl/rms_vector_normalizer_unit.sv =====
// Load: square on the shared multiplier, then saturating add to the sum.
// Emit: read, scale, optional weighting and clip, then the result is registered;
//   the first emit of a vector adds two 65-step divisions and a 32-step root, one
//   division if mean square + epsilon <= 1. Not-ready emit: a zero. One at a time.
// Reset: synchronous, active high; resets control and CSRs, clears counts, sum, valid.
//   The sample memory and the datapath registers are not cleared.
// ----------------------------------------------------------------------------
// RMS vector normaliser
// Buffers a vector, accumulates its squares and emits each sample scaled by
// 1/sqrt(mean square + epsilon), optionally weighted, saturated to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_vector_normalizer_unit
   import rvn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // sample[31:0], weight[47:32]
   input  wire logic        req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // value[31:0]
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser,   // status[1:0]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [31:0] mem [MAX_LENGTH];
   logic [31:0] rd_data_ff;

   rvn_state_type state_ff, state_in;

   logic [LEN_W-1:0] vlen_ff, vlen_in;
   logic [15:0]      eps_ff, eps_in;
   logic             usew_ff, usew_in;

   logic [LEN_W-1:0] loaded_ff, loaded_in;
   logic [LEN_W-1:0] emitted_ff, emitted_in;
   logic [63:0]      sum_ff, sum_in;
   logic [31:0]      inv_ff, inv_in;
   logic             ready_ff, ready_in;
   logic [6:0]       cnt_ff, cnt_in;

   logic [31:0] smag_ff, smag_in;
   logic [15:0] wm_ff, wm_in;
   logic        neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [64:0] dvd_ff, dvd_in;
   logic [63:0] dvsr_ff, dvsr_in;
   logic [63:0] rem_ff, rem_in;

   logic [31:0] pval_ff, pval_in;
   logic        plast_ff, plast_in;
   logic [1:0]  pstat_ff, pstat_in;

   logic        rvalid_ff, rvalid_in;
   logic [31:0] rdata_ff, rdata_in;
   logic        rlast_ff, rlast_in;
   logic [1:0]  ruser_ff, ruser_in;

   logic [LEN_W-1:0] len;
   logic             mem_we;
   logic [31:0]      mul_a, mul_b;
   logic [64:0]      sub_a, sub_b;
   logic [65:0]      diff;
   logic             ge;
   logic [64:0]      rem_sh;
   logic [35:0]      sq_sh;
   logic [64:0]      wide_sum;
   logic [63:0]      mean;
   logic [31:0]      xmag;
   logic [63:0]      wsum;
   logic             fin_neg;
   logic             req_fire;
   logic [31:0]      req_sample;
   logic [15:0]      req_weight;

   assign req_sample = req_tdata[31:0];
   assign req_weight = req_tdata[47:32];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = ruser_ff;

   always_comb begin
      if (vlen_ff == '0) begin
         len = LEN_W'(1);
      end else if (vlen_ff > LEN_W'(MAX_LENGTH)) begin
         len = LEN_W'(MAX_LENGTH);
      end else begin
         len = vlen_ff;
      end
   end

   // shared multiplier
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // shared compare/subtract
   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge   = ~diff[65];

   assign rem_sh   = {rem_ff, dvd_ff[64]};
   assign sq_sh    = {rem_ff[33:0], dvd_ff[63:62]};
   assign wide_sum = {1'b0, dvd_ff[63:0]} + {49'd0, eps_ff};
   assign mean     = wide_sum[64] ? '1 : wide_sum[63:0];
   assign xmag     = rd_data_ff[31] ? (32'd0 - rd_data_ff) : rd_data_ff;
   assign wsum     = acc_ff + {prod_ff[31:0], 32'd0};
   assign fin_neg  = neg_ff && (acc_ff != '0);

   always_comb begin
      state_in   = state_ff;
      vlen_in    = vlen_ff;
      eps_in     = eps_ff;
      usew_in    = usew_ff;
      loaded_in  = loaded_ff;
      emitted_in = emitted_ff;
      sum_in     = sum_ff;
      inv_in     = inv_ff;
      ready_in   = ready_ff;
      cnt_in     = cnt_ff;
      smag_in    = smag_ff;
      wm_in      = wm_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      dvd_in     = dvd_ff;
      dvsr_in    = dvsr_ff;
      rem_in     = rem_ff;
      pval_in    = pval_ff;
      plast_in   = plast_ff;
      pstat_in   = pstat_ff;
      rvalid_in  = rvalid_ff;
      rdata_in   = rdata_ff;
      rlast_in   = rlast_ff;
      ruser_in   = ruser_ff;
      mem_we     = 1'b0;
      mul_a      = smag_ff;
      mul_b      = smag_ff;
      sub_a      = rem_sh;
      sub_b      = {1'b0, dvsr_ff};

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_LENGTH:  vlen_in = csr_data[LEN_W-1:0];
            CSR_EPSILON: eps_in  = csr_data;
            CSR_WEIGHTS: usew_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_LOAD) begin
                  if (loaded_ff < len) begin
                     mem_we    = 1'b1;
                     loaded_in = loaded_ff + LEN_W'(1);
                     smag_in   = req_sample[31] ? (32'd0 - req_sample) : req_sample;
                     state_in  = S_LD_SQ;
                  end else begin
                     state_in = S_DROP;
                  end
               end else begin
                  wm_in = req_weight[15] ? (16'd0 - req_weight) : req_weight;
                  if (loaded_ff < len) begin
                     pval_in  = '0;
                     plast_in = 1'b0;
                     pstat_in = STATUS_NOT_READY;
                     state_in = S_PUSH;
                  end else if (!ready_ff) begin
                     dvd_in   = {1'b0, sum_ff};
                     dvsr_in  = 64'(len);
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_RT_DIV1;
                  end else begin
                     state_in = S_EM_READ;
                  end
                  neg_in = usew_ff && req_weight[15];
               end
            end
         end
         S_DROP: begin
            state_in = S_IDLE;
         end
         S_LD_SQ: begin
            state_in = S_LD_ACC;
         end
         S_LD_ACC: begin
            sub_a    = {1'b0, sum_ff};
            sub_b    = {1'b0, ~prod_ff};
            sum_in   = ge ? '1 : sum_ff + prod_ff;
            state_in = S_IDLE;
         end
         S_RT_DIV1, S_RT_DIV2: begin
            rem_in = ge ? diff[63:0] : rem_sh[63:0];
            dvd_in = {dvd_ff[63:0], ge};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               cnt_in = '0;
               if (state_ff == S_RT_DIV1) begin
                  state_in = S_RT_MEAN;
               end else begin
                  rem_in   = '0;
                  inv_in   = '0;
                  state_in = S_RT_SQRT;
               end
            end
         end
         S_RT_MEAN: begin
            if (mean <= 64'd1) begin
               inv_in   = '1;
               ready_in = 1'b1;
               state_in = S_EM_READ;
            end else begin
               dvsr_in  = mean;
               dvd_in   = {1'b1, 64'd0};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_RT_DIV2;
            end
         end
         S_RT_SQRT: begin
            sub_a  = 65'(sq_sh);
            sub_b  = 65'({inv_ff, 2'b01});
            rem_in = ge ? 64'(diff[35:0]) : 64'(sq_sh);
            inv_in = {inv_ff[30:0], ge};
            dvd_in = {dvd_ff[62:0], 2'b00};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd31) begin
               cnt_in   = '0;
               ready_in = 1'b1;
               state_in = S_EM_READ;
            end
         end
         S_EM_READ: begin
            state_in = S_EM_SCALE;
         end
         S_EM_SCALE: begin
            mul_a    = xmag;
            mul_b    = inv_ff;
            neg_in   = neg_ff ^ rd_data_ff[31];
            state_in = S_EM_MAG;
         end
         S_EM_MAG: begin
            acc_in   = {16'd0, prod_ff[63:16]};
            state_in = usew_ff ? S_EM_WLO : S_EM_CLIP;
         end
         S_EM_WLO: begin
            mul_a    = acc_ff[31:0];
            mul_b    = {16'd0, wm_ff};
            state_in = S_EM_WHI;
         end
         S_EM_WHI: begin
            mul_a    = {16'd0, acc_ff[47:32]};
            mul_b    = {16'd0, wm_ff};
            acc_in   = prod_ff;
            state_in = S_EM_WSUM;
         end
         S_EM_WSUM: begin
            acc_in   = wsum >> 12;
            state_in = S_EM_CLIP;
         end
         S_EM_CLIP: begin
            pstat_in = STATUS_OK;
            if (fin_neg) begin
               if (acc_ff > 64'h8000_0000) begin
                  pval_in  = 32'h8000_0000;
                  pstat_in = STATUS_SATURATED;
               end else begin
                  pval_in = 32'd0 - acc_ff[31:0];
               end
            end else begin
               if (acc_ff > 64'h7FFF_FFFF) begin
                  pval_in  = 32'h7FFF_FFFF;
                  pstat_in = STATUS_SATURATED;
               end else begin
                  pval_in = acc_ff[31:0];
               end
            end
            plast_in = (emitted_ff + LEN_W'(1)) >= len;
            if ((emitted_ff + LEN_W'(1)) >= len) begin
               loaded_in  = '0;
               emitted_in = '0;
               sum_in     = '0;
               inv_in     = '0;
               ready_in   = 1'b0;
            end else begin
               emitted_in = emitted_ff + LEN_W'(1);
            end
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rdata_in  = pval_ff;
               rlast_in  = plast_ff;
               ruser_in  = pstat_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[loaded_ff[ADDR_W-1:0]] <= req_sample;
      end
      rd_data_ff <= mem[emitted_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         vlen_ff    <= LENGTH_RESET;
         eps_ff     <= EPSILON_RESET;
         usew_ff    <= WEIGHTS_RESET;
         loaded_ff  <= '0;
         emitted_ff <= '0;
         sum_ff     <= '0;
         inv_ff     <= '0;
         ready_ff   <= 1'b0;
         cnt_ff     <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vlen_ff    <= vlen_in;
         eps_ff     <= eps_in;
         usew_ff    <= usew_in;
         loaded_ff  <= loaded_in;
         emitted_ff <= emitted_in;
         sum_ff     <= sum_in;
         inv_ff     <= inv_in;
         ready_ff   <= ready_in;
         cnt_ff     <= cnt_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      smag_ff  <= smag_in;
      wm_ff    <= wm_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      dvd_ff   <= dvd_in;
      dvsr_ff  <= dvsr_in;
      rem_ff   <= rem_in;
      pval_ff  <= pval_in;
      plast_ff <= plast_in;
      pstat_ff <= pstat_in;
      rdata_ff <= rdata_in;
      rlast_ff <= rlast_in;
      ruser_ff <= ruser_in;
   end

endmodule

`default_nettype wire

// ===== rtl/rvn_checker.sv =====
// ----------------------------------------------------------------------------
// RMS vector normaliser port checker
// Port-level properties of the normaliser, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rms_vector_normalizer_unit_defines.svh"

module rvn_checker
   import rvn_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,   // value[31:0]
   input wire logic        rsp_tlast,
   input wire logic [1:0]  rsp_tuser    // status[1:0]
);

   `RVN_ASSERT_NXT_NR(a_reset_quiet, reset, !rsp_tvalid, "result valid after reset")

   `RVN_ASSERT_NXT(a_busy_after_transfer, req_tvalid && req_tready, !req_tready, "ready held after transfer")

   `RVN_ASSERT_IMP(a_not_ready_empty, rsp_tvalid && (rsp_tuser == STATUS_NOT_READY), (rsp_tdata == 32'd0) && !rsp_tlast, "not-ready result carries data")

   `RVN_ASSERT_IMP(a_sat_limits, rsp_tvalid && (rsp_tuser == STATUS_SATURATED), (rsp_tdata == 32'h7FFF_FFFF) || (rsp_tdata == 32'h8000_0000), "saturated value off the rails")

   `RVN_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind rms_vector_normalizer_unit rvn_checker u_rvn_checker (.*);

`default_nettype wire
